[rtl/fcfs_pkg.sv]
// ----------------------------------------------------------------------------
// fcfs_pkg
// Types and constants shared by the free chunk fit search block.
// ----------------------------------------------------------------------------
package fcfs_pkg;

  localparam int unsigned MAP_DEPTH = 1024;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam int unsigned LEN_W     = $clog2(MAP_DEPTH + 1);

  localparam int unsigned OFFSET_W  = 10;
  localparam int unsigned VALUE_W   = 4;
  localparam int unsigned REQ_W     = 11;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned CLEN_W    = 11;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic STRAT_FIRST = 1'b0;
  localparam logic STRAT_WORST = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

[rtl/free_chunk_fit_search_core.sv]
// ----------------------------------------------------------------------------
// free_chunk_fit_search_core
// First-fit and worst-fit search for a free run in a per-byte allocation map.
// ----------------------------------------------------------------------------
// The map is a 1024 x 1 synchronous memory. After reset a clearing pass
// marks every byte free; no input transfer is taken during it, while
// configuration writes are. A write item is written into the map on its
// transfer. A search item reads the map one entry per cycle through the
// single read port, up to n entries, where n is the active region length
// (at most 1024); its result is registered from the finish state, and the
// next item is taken back in idle. A first-fit search ends early at the
// first run that fits; a zero request or an empty region skips the scan.
// One item is worked on at a time. The result register lets the next item be
// taken while a result still waits for its transfer; a finished search waits
// only while an earlier result has not been taken.
module free_chunk_fit_search_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata, from the lowest bit: entry_offset[9:0], entry_value[13:10],
  // request_size[24:14], zero fill.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [fcfs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: opcode.
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, from the lowest bit: chunk_address[15:0], chunk_length[26:16],
  // zero fill.
  output logic [fcfs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: found.
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fcfs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fcfs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import fcfs_pkg::*;

  logic                  map_mem [MAP_DEPTH];
  logic                  rdata_q;

  state_e                state_q, state_d;
  logic [MAP_AW-1:0]     clr_q, clr_d;
  logic [LEN_W-1:0]      issue_q, issue_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [MAP_AW-1:0]     pos_q, pos_d;
  logic [LEN_W-1:0]      run_q, run_d;
  logic [MAP_AW-1:0]     run_start_q, run_start_d;
  logic [LEN_W-1:0]      best_q, best_d;
  logic [MAP_AW-1:0]     best_start_q, best_start_d;
  logic                  hit_q, hit_d;
  logic [MAP_AW-1:0]     hit_start_q, hit_start_d;
  logic [REQ_W-1:0]      req_q, req_d;
  logic [LEN_W-1:0]      n_q, n_d;

  logic                  strategy_q;
  logic [ADDR_W-1:0]     base_q;
  logic [LEN_W-1:0]      length_q;

  logic                  out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_user_q, out_user_d;

  logic                  mem_we;
  logic [MAP_AW-1:0]     mem_waddr;
  logic                  mem_wdata;
  logic                  mem_re;

  logic                  in_xfer;
  logic [OFFSET_W-1:0]   in_offset;
  logic [VALUE_W-1:0]    in_value;
  logic [REQ_W-1:0]      in_req;
  logic [LEN_W-1:0]      run_nx;
  logic [LEN_W-1:0]      ff_start;
  logic                  res_found;
  logic [MAP_AW-1:0]     res_start;
  logic [CLEN_W-1:0]     res_len;
  logic [ADDR_W-1:0]     res_addr;

  assign in_offset = s_axis_tdata[OFFSET_W-1:0];
  assign in_value  = s_axis_tdata[OFFSET_W+VALUE_W-1:OFFSET_W];
  assign in_req    = s_axis_tdata[OFFSET_W+VALUE_W+REQ_W-1:OFFSET_W+VALUE_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[issue_q[MAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= STRAT_FIRST;
      base_q     <= '0;
      length_q   <= LEN_W'(MAP_DEPTH);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_STRATEGY: strategy_q <= cfg_data_i[0];
        CFG_BASE:     base_q     <= cfg_data_i[ADDR_W-1:0];
        CFG_LENGTH:   length_q   <= cfg_data_i[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q      <= issue_d;
    pos_q        <= pos_d;
    run_q        <= run_d;
    run_start_q  <= run_start_d;
    best_q       <= best_d;
    best_start_q <= best_start_d;
    hit_q        <= hit_d;
    hit_start_q  <= hit_start_d;
    req_q        <= req_d;
    n_q          <= n_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  assign run_nx   = rdata_q ? '0 : run_q + LEN_W'(1);
  assign ff_start = LEN_W'({1'b0, pos_q}) + LEN_W'(1) - LEN_W'(req_q);

  always_comb begin
    if (strategy_q == STRAT_WORST) begin
      res_found = (req_q != '0) && (LEN_W'(req_q) <= best_q);
      res_start = best_start_q;
      res_len   = CLEN_W'(best_q);
    end else begin
      res_found = hit_q;
      res_start = hit_start_q;
      res_len   = CLEN_W'(req_q);
    end
    res_addr = base_q + ADDR_W'(res_start);
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    pos_d        = issue_q[MAP_AW-1:0];
    run_d        = run_q;
    run_start_d  = run_start_q;
    best_d       = best_q;
    best_start_d = best_start_q;
    hit_d        = hit_q;
    hit_start_d  = hit_start_q;
    req_d        = req_q;
    n_d          = n_q;
    out_vld_d    = out_vld_q;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    mem_we       = 1'b0;
    mem_waddr    = in_offset;
    mem_wdata    = (in_value != '0);
    mem_re       = 1'b0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 1'b0;
        clr_d     = clr_q + MAP_AW'(1);
        if (clr_q == MAP_AW'(MAP_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            req_d   = in_req;
            n_d     = (length_q > LEN_W'(MAP_DEPTH)) ? LEN_W'(MAP_DEPTH) : length_q;
            issue_d = '0;
            run_d   = '0;
            best_d  = '0;
            hit_d   = 1'b0;
            if (in_req == '0 || length_q == '0) begin
              state_d = ST_FINISH;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (issue_q != n_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          issue_d  = issue_q + LEN_W'(1);
        end
        if (rd_vld_q) begin
          run_d = run_nx;
          if (!rdata_q && run_q == '0) begin
            run_start_d = pos_q;
          end
          if (!rdata_q && run_nx > best_q) begin
            best_d       = run_nx;
            best_start_d = (run_q == '0) ? pos_q : run_start_q;
          end
          if (strategy_q == STRAT_FIRST && run_nx == LEN_W'(req_q)) begin
            hit_d       = 1'b1;
            hit_start_d = ff_start[MAP_AW-1:0];
            state_d     = ST_FINISH;
          end
        end else if (issue_q == n_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_user_d = res_found;
          if (res_found) begin
            out_data_d = OUT_DATA_W'({res_len, res_addr});
          end else begin
            out_data_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
